@@ hw/rtl/uart_rb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the serial-port transmit/receive ring buffers.
// No dependencies; used by uart_rb_tx_queue, uart_rb_rx_queue and the top level.
package uart_rb_pkg;

    // Queue sizes (slots); each queue keeps one slot empty
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH);

    // Characters with special handling
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Request kinds
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_GET   = 2'd1;
    localparam logic [1:0] REQ_RXBYT = 2'd2;
    localparam logic [1:0] REQ_TXRDY = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TX_FULL  = 3'd1;
    localparam logic [2:0] ST_RX_EMPTY = 3'd2;
    localparam logic [2:0] ST_RX_OVRN  = 3'd3;
    localparam logic [2:0] ST_TX_EMPTY = 3'd4;

    // Transmit queue command and response
    typedef struct packed {
        logic       put;
        logic       pop;
        logic [7:0] data;
    } tx_cmd_t;

    typedef struct packed {
        logic       rejected;
        logic       empty;
        logic [7:0] data;
        logic       irq_on;
    } tx_rsp_t;

    // Receive queue command and response
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } rx_cmd_t;

    typedef struct packed {
        logic       overrun;
        logic       empty;
        logic [7:0] data;
        logic       ready;
    } rx_rsp_t;

endpackage

@@ hw/rtl/uart_rb_tx_queue.sv @@
`timescale 1ns / 1ps
// Transmit ring buffer: store, pointers and transmit interrupt enable.
// Depends on uart_rb_pkg for sizes, characters and command/response types.
module uart_rb_tx_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  uart_rb_pkg::tx_cmd_t cmd,
    output uart_rb_pkg::tx_rsp_t rsp
);

    localparam int W = uart_rb_pkg::TX_PTR_W;
    localparam logic [W-1:0] PTR_LAST = W'(uart_rb_pkg::TX_DEPTH - 1);
    localparam logic [W-1:0] PTR_ONE  = W'(1);

    logic [7:0]   store_reg [uart_rb_pkg::TX_DEPTH];
    logic [W-1:0] wr_ptr_reg;
    logic [W-1:0] wr_ptr_next;
    logic [W-1:0] rd_ptr_reg;
    logic [W-1:0] rd_ptr_next;
    logic         irq_on_reg;
    logic         irq_on_next;

    logic [W-1:0] wr1;
    logic [W-1:0] wr2;
    logic [W-1:0] rd1;
    logic         is_lf;
    logic         empty;
    logic         put_ok;
    logic         pop_ok;

    // Pointer increments, wrapping at the queue depth
    assign wr1   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
    assign wr2   = (wr1 == PTR_LAST) ? '0 : wr1 + PTR_ONE;
    assign rd1   = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
    assign is_lf = (cmd.data == uart_rb_pkg::CH_LF);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    // A line feed needs two free slots (CR then LF), anything else one
    assign put_ok = cmd.put && (wr1 != rd_ptr_reg) && (!is_lf || (wr2 != rd_ptr_reg));
    assign pop_ok = cmd.pop && !empty;

    // Next pointer and interrupt enable values
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        irq_on_next = irq_on_reg;
        if (put_ok)
        begin
            wr_ptr_next = is_lf ? wr2 : wr1;
            irq_on_next = 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = rd1;
        end
        if (cmd.pop && empty)
        begin
            irq_on_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            irq_on_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            irq_on_reg <= irq_on_next;
        end
    end

    // Slot store: a line feed writes CR and LF into two consecutive slots
    always_ff @(posedge clk)
    begin
        if (put_ok)
        begin
            if (is_lf)
            begin
                store_reg[wr1] <= uart_rb_pkg::CH_CR;
                store_reg[wr2] <= cmd.data;
            end
            else
            begin
                store_reg[wr1] <= cmd.data;
            end
        end
    end

    // Response to the current command
    always_comb
    begin
        rsp.rejected = cmd.put && !put_ok;
        rsp.empty    = empty;
        rsp.data     = store_reg[rd1];
        rsp.irq_on   = irq_on_next;
    end

endmodule

@@ hw/rtl/uart_rb_rx_queue.sv @@
`timescale 1ns / 1ps
// Receive ring buffer: store and pointers, with overrun drop.
// Depends on uart_rb_pkg for sizes and command/response types.
module uart_rb_rx_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  uart_rb_pkg::rx_cmd_t cmd,
    output uart_rb_pkg::rx_rsp_t rsp
);

    localparam int W = uart_rb_pkg::RX_PTR_W;
    localparam logic [W-1:0] PTR_LAST = W'(uart_rb_pkg::RX_DEPTH - 1);
    localparam logic [W-1:0] PTR_ONE  = W'(1);

    logic [7:0]   store_reg [uart_rb_pkg::RX_DEPTH];
    logic [W-1:0] wr_ptr_reg;
    logic [W-1:0] wr_ptr_next;
    logic [W-1:0] rd_ptr_reg;
    logic [W-1:0] rd_ptr_next;

    logic [W-1:0] wr1;
    logic [W-1:0] rd1;
    logic         empty;
    logic         full;
    logic         push_ok;
    logic         pop_ok;

    // Pointer increments, wrapping at the queue depth
    assign wr1     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
    assign rd1     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr1 == rd_ptr_reg);
    assign push_ok = cmd.push && !full;
    assign pop_ok  = cmd.pop && !empty;

    assign wr_ptr_next = push_ok ? wr1 : wr_ptr_reg;
    assign rd_ptr_next = pop_ok ? rd1 : rd_ptr_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Slot store
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            store_reg[wr1] <= cmd.data;
        end
    end

    // Response to the current command; ready reflects the state after it
    always_comb
    begin
        rsp.overrun = cmd.push && full;
        rsp.empty   = empty;
        rsp.data    = store_reg[rd1];
        rsp.ready   = (wr_ptr_next != rd_ptr_next);
    end

endmodule

@@ hw/rtl/uart_tx_rx_ring_buffers.sv @@
`timescale 1ns / 1ps
// Channel    | Handshake              | Payload
// -----------+------------------------+--------------------------------------------
// request    | in_valid / in_stall    | req_type[1:0], byte_in[7:0]
// result     | out_valid / out_stall  | status[2:0], byte_out[7:0], byte_valid,
//            |                        | rx_ready, tx_irq_enable
//
// One item per cycle sustained while the result is not stalled; an accepted item is held
// in the input register, and its result is loaded into the result register as it moves on.
// The queue update for an item happens in one pass as it moves from the input
// register into the result register, so the next item already sees its effect.
// Reset empties both queues and clears the transmit interrupt enable.
// A stalled result holds the result register and the input register; in_stall
// rises only when the input register is full and cannot move on.
// Top level of the serial-port ring buffers; depends on uart_rb_pkg,
// uart_rb_tx_queue and uart_rb_rx_queue.
module uart_tx_rx_ring_buffers (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] byte_out,
    output logic       byte_valid,
    output logic       rx_ready,
    output logic       tx_irq_enable
);

    // Input register
    logic       s1_valid_reg;
    logic [1:0] s1_req_reg;
    logic [7:0] s1_byte_reg;

    // Result register
    logic       out_valid_reg;
    logic [2:0] status_reg;
    logic [7:0] byte_out_reg;
    logic       byte_valid_reg;
    logic       rx_ready_reg;
    logic       tx_irq_reg;

    logic [2:0] status_next;
    logic [7:0] byte_out_next;
    logic       byte_valid_next;

    logic advance;
    logic fire;
    logic accept;

    uart_rb_pkg::tx_cmd_t tx_cmd;
    uart_rb_pkg::tx_rsp_t tx_rsp;
    uart_rb_pkg::rx_cmd_t rx_cmd;
    uart_rb_pkg::rx_rsp_t rx_rsp;

    // Flow control: the input register moves on when the result register frees up
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Queue commands for the item in the input register
    assign tx_cmd.put  = fire && (s1_req_reg == uart_rb_pkg::REQ_PUT);
    assign tx_cmd.pop  = fire && (s1_req_reg == uart_rb_pkg::REQ_TXRDY);
    assign tx_cmd.data = s1_byte_reg;
    assign rx_cmd.push = fire && (s1_req_reg == uart_rb_pkg::REQ_RXBYT);
    assign rx_cmd.pop  = fire && (s1_req_reg == uart_rb_pkg::REQ_GET);
    assign rx_cmd.data = s1_byte_reg;

    uart_rb_tx_queue u_tx_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tx_cmd),
        .rsp   (tx_rsp)
    );

    uart_rb_rx_queue u_rx_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .rsp   (rx_rsp)
    );

    // Result fields for the item in the input register
    always_comb
    begin
        status_next     = uart_rb_pkg::ST_OK;
        byte_out_next   = 8'h00;
        byte_valid_next = 1'b0;
        unique case (s1_req_reg)
            uart_rb_pkg::REQ_PUT:
            begin
                if (tx_rsp.rejected)
                begin
                    status_next = uart_rb_pkg::ST_TX_FULL;
                end
            end
            uart_rb_pkg::REQ_GET:
            begin
                if (rx_rsp.empty)
                begin
                    status_next = uart_rb_pkg::ST_RX_EMPTY;
                end
                else
                begin
                    // carriage return reads back as line feed
                    byte_out_next   = (rx_rsp.data == uart_rb_pkg::CH_CR) ?
                                      uart_rb_pkg::CH_LF : rx_rsp.data;
                    byte_valid_next = 1'b1;
                end
            end
            uart_rb_pkg::REQ_RXBYT:
            begin
                if (rx_rsp.overrun)
                begin
                    status_next = uart_rb_pkg::ST_RX_OVRN;
                end
            end
            uart_rb_pkg::REQ_TXRDY:
            begin
                if (tx_rsp.empty)
                begin
                    status_next = uart_rb_pkg::ST_TX_EMPTY;
                end
                else
                begin
                    byte_out_next   = tx_rsp.data;
                    byte_valid_next = 1'b1;
                end
            end
            default:
            begin
                status_next = uart_rb_pkg::ST_OK;
            end
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req_type;
            s1_byte_reg <= byte_in;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg     <= status_next;
            byte_out_reg   <= byte_out_next;
            byte_valid_reg <= byte_valid_next;
            rx_ready_reg   <= rx_rsp.ready;
            tx_irq_reg     <= tx_rsp.irq_on;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign byte_out      = byte_out_reg;
    assign byte_valid    = byte_valid_reg;
    assign rx_ready      = rx_ready_reg;
    assign tx_irq_enable = tx_irq_reg;

    // A byte is only handed out with ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (status == uart_rb_pkg::ST_OK))
        else $error("byte_valid with non-ok status");

    // No byte means a zero byte field
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (byte_out == 8'h00))
        else $error("byte_out nonzero without byte_valid");

    // An empty transmit queue on transmitter ready drops the interrupt enable
    a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == uart_rb_pkg::ST_TX_EMPTY)) |-> !tx_irq_enable)
        else $error("tx irq enable left on with empty queue");

    // A get from an empty receive queue leaves it empty
    a_rx_empty_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == uart_rb_pkg::ST_RX_EMPTY)) |-> !rx_ready)
        else $error("rx_ready set after get from empty queue");

    // An item cannot leave the input register while the result is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && s1_valid_reg) |=> s1_valid_reg)
        else $error("input register dropped an item under stall");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the serial-port transmit/receive ring buffers.
// Depends on uart_rb_pkg and uart_tx_rx_ring_buffers; a local queue model predicts every result.
module tb;

    // One result of the block, in output port order
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       rx_ready;
        logic       irq;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] req_type;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       rx_ready;
    logic       tx_irq_enable;

    // Queue model state
    logic [7:0] tx_slots [uart_rb_pkg::TX_DEPTH];
    logic [7:0] rx_slots [uart_rb_pkg::RX_DEPTH];
    int         tx_wr;
    int         tx_rd;
    int         rx_wr;
    int         rx_rd;
    logic       irq_state;

    result_t    pending_results [$];
    int         errors = 0;
    int         hold_cycles = 0;
    bit         tx_gaps_on = 1'b0;
    bit         rx_gaps_on = 1'b0;

    uart_tx_rx_ring_buffers dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .byte_out      (byte_out),
        .byte_valid    (byte_valid),
        .rx_ready      (rx_ready),
        .tx_irq_enable (tx_irq_enable)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bytes held in each queue
    function automatic int tx_count();
        return (tx_wr + uart_rb_pkg::TX_DEPTH - tx_rd) % uart_rb_pkg::TX_DEPTH;
    endfunction

    function automatic int rx_count();
        return (rx_wr + uart_rb_pkg::RX_DEPTH - rx_rd) % uart_rb_pkg::RX_DEPTH;
    endfunction

    // Apply one item to the queue model and return the result it gives
    function automatic result_t predict_item(input logic [1:0] kind, input logic [7:0] value);
        result_t    r;
        int         need;
        int         nxt;
        logic [7:0] c;
        r = '0;
        case (kind)
            uart_rb_pkg::REQ_PUT:
            begin
                need = (value == uart_rb_pkg::CH_LF) ? 2 : 1;
                if (uart_rb_pkg::TX_DEPTH - 1 - tx_count() < need)
                begin
                    r.status = uart_rb_pkg::ST_TX_FULL;
                end
                else
                begin
                    // line feed goes out as CR then LF
                    if (value == uart_rb_pkg::CH_LF)
                    begin
                        tx_wr = (tx_wr + 1) % uart_rb_pkg::TX_DEPTH;
                        tx_slots[tx_wr] = uart_rb_pkg::CH_CR;
                    end
                    tx_wr = (tx_wr + 1) % uart_rb_pkg::TX_DEPTH;
                    tx_slots[tx_wr] = value;
                    irq_state = 1'b1;
                end
            end
            uart_rb_pkg::REQ_GET:
            begin
                if (rx_count() == 0)
                begin
                    r.status = uart_rb_pkg::ST_RX_EMPTY;
                end
                else
                begin
                    rx_rd = (rx_rd + 1) % uart_rb_pkg::RX_DEPTH;
                    c = rx_slots[rx_rd];
                    r.byte_out = (c == uart_rb_pkg::CH_CR) ? uart_rb_pkg::CH_LF : c;
                    r.byte_valid = 1'b1;
                end
            end
            uart_rb_pkg::REQ_RXBYT:
            begin
                nxt = (rx_wr + 1) % uart_rb_pkg::RX_DEPTH;
                if (nxt == rx_rd)
                begin
                    r.status = uart_rb_pkg::ST_RX_OVRN;
                end
                else
                begin
                    rx_wr = nxt;
                    rx_slots[nxt] = value;
                end
            end
            default:
            begin
                if (tx_count() != 0)
                begin
                    tx_rd = (tx_rd + 1) % uart_rb_pkg::TX_DEPTH;
                    r.byte_out = tx_slots[tx_rd];
                    r.byte_valid = 1'b1;
                end
                else
                begin
                    irq_state = 1'b0;
                    r.status = uart_rb_pkg::ST_TX_EMPTY;
                end
            end
        endcase
        r.rx_ready = (rx_count() != 0);
        r.irq = irq_state;
        return r;
    endfunction

    // Offer one item, after a random gap when sender gaps are on; predict its result once accepted
    task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        byte_in  <= value;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_item(kind, value));
    endtask

    // Stop offering until every expected result has come back
    task automatic pause_sender();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Random byte with line feed and carriage return weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return uart_rb_pkg::CH_LF;
            1:       return uart_rb_pkg::CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Request kind; mode 0 mixed, 1 filling, 2 draining
    function automatic logic [1:0] pick_kind(input int mode);
        int w;
        w = $urandom_range(0, 99);
        case (mode)
            1:       return (w < 40) ? uart_rb_pkg::REQ_PUT :
                            (w < 80) ? uart_rb_pkg::REQ_RXBYT :
                            (w < 90) ? uart_rb_pkg::REQ_GET : uart_rb_pkg::REQ_TXRDY;
            2:       return (w < 10) ? uart_rb_pkg::REQ_PUT :
                            (w < 20) ? uart_rb_pkg::REQ_RXBYT :
                            (w < 60) ? uart_rb_pkg::REQ_GET : uart_rb_pkg::REQ_TXRDY;
            default: return 2'($urandom_range(0, 3));
        endcase
    endfunction

    // Receiver: random stall after each result when receiver gaps are on, plus long holds on request
    initial
    begin : receiver
        int left;
        left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall && rx_gaps_on)
                left = $urandom_range(0, 15);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (left > 0)
            begin
                left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, byte_out, byte_valid, rx_ready, tx_irq_enable};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status=%0d byte=%02h valid=%b %s%b irq=%b",
                             got.status, got.byte_out, got.byte_valid, "rx_ready=",
                             got.rx_ready, got.irq);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.byte_out !== want.byte_out ||
                    got.byte_valid !== want.byte_valid || got.rx_ready !== want.rx_ready ||
                    got.irq !== want.irq)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at %0t: exp status=%0d byte=%02h valid=%b %s%b irq=%b",
                                 $realtime, want.status, want.byte_out, want.byte_valid,
                                 "rx_ready=", want.rx_ready, want.irq);
                        $display("    got status=%0d byte=%02h valid=%b rx_ready=%b irq=%b",
                                 got.status, got.byte_out, got.byte_valid, got.rx_ready,
                                 got.irq);
                    end
                end
            end
        end
    end

    // Extremes of both fields, every request kind, empty cases, CR/LF handling
    task automatic test_directed();
        send_item(uart_rb_pkg::REQ_PUT, 8'h41);
        send_item(uart_rb_pkg::REQ_PUT, uart_rb_pkg::CH_LF);
        send_item(uart_rb_pkg::REQ_PUT, 8'h00);
        send_item(uart_rb_pkg::REQ_PUT, 8'hFF);
        send_item(uart_rb_pkg::REQ_PUT, uart_rb_pkg::CH_CR);
        repeat (6) send_item(uart_rb_pkg::REQ_TXRDY, 8'h00);
        // empty transmit queue clears the enable, then is served with it off
        send_item(uart_rb_pkg::REQ_TXRDY, 8'hFF);
        send_item(uart_rb_pkg::REQ_TXRDY, 8'h00);
        send_item(uart_rb_pkg::REQ_GET, 8'hFF);
        send_item(uart_rb_pkg::REQ_RXBYT, 8'h00);
        send_item(uart_rb_pkg::REQ_RXBYT, 8'hFF);
        send_item(uart_rb_pkg::REQ_RXBYT, uart_rb_pkg::CH_CR);
        send_item(uart_rb_pkg::REQ_RXBYT, uart_rb_pkg::CH_LF);
        repeat (5) send_item(uart_rb_pkg::REQ_GET, 8'h00);
    endtask

    // Transmit queue full: line feed needs two free slots, others need one
    task automatic test_tx_full();
        logic [7:0] b;
        repeat (uart_rb_pkg::TX_DEPTH - 2)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == uart_rb_pkg::CH_LF)
                b = uart_rb_pkg::CH_CR;
            send_item(uart_rb_pkg::REQ_PUT, b);
        end
        send_item(uart_rb_pkg::REQ_PUT, uart_rb_pkg::CH_LF);
        send_item(uart_rb_pkg::REQ_PUT, 8'h5A);
        send_item(uart_rb_pkg::REQ_PUT, 8'h59);
        send_item(uart_rb_pkg::REQ_TXRDY, 8'h00);
        send_item(uart_rb_pkg::REQ_PUT, uart_rb_pkg::CH_LF);
        send_item(uart_rb_pkg::REQ_TXRDY, 8'h00);
        send_item(uart_rb_pkg::REQ_PUT, uart_rb_pkg::CH_LF);
        repeat (uart_rb_pkg::TX_DEPTH) send_item(uart_rb_pkg::REQ_TXRDY, 8'h00);
    endtask

    // Receive overrun drops the byte; queue contents stay intact
    task automatic test_rx_overrun();
        repeat (uart_rb_pkg::RX_DEPTH - 1) send_item(uart_rb_pkg::REQ_RXBYT, pick_byte());
        send_item(uart_rb_pkg::REQ_RXBYT, 8'hA5);
        send_item(uart_rb_pkg::REQ_RXBYT, uart_rb_pkg::CH_CR);
        repeat (uart_rb_pkg::RX_DEPTH) send_item(uart_rb_pkg::REQ_GET, 8'h00);
    endtask

    // Long receiver hold while items keep coming, then wait for every result to come back
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_cycles = 100;
        repeat (40) send_item(pick_kind(0), pick_byte());
        pause_sender();
    endtask

    // Random phases that fill, drain or mix, with varying idle patterns
    task automatic test_random();
        int mode;
        for (int phase = 0; phase < 16; phase++)
        begin
            mode = $urandom_range(0, 2);
            if (phase == 0)
            begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            else
            begin
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            repeat (50) send_item(pick_kind(mode), pick_byte());
            if ($urandom_range(0, 3) == 0)
                pause_sender();
        end
    endtask

    // Test sequence
    initial
    begin : main
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        req_type <= uart_rb_pkg::REQ_PUT;
        byte_in  <= 8'h00;
        tx_wr = 0;
        tx_rd = 0;
        rx_wr = 0;
        rx_rd = 0;
        irq_state = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        test_tx_full();
        test_rx_overrun();
        test_backpressure();
        test_random();

        pause_sender();
        repeat (20) @(posedge clk);
        errors += pending_results.size();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

@@ uart_tx_rx_ring_buffers.f @@
hw/rtl/uart_rb_pkg.sv
hw/rtl/uart_rb_tx_queue.sv
hw/rtl/uart_rb_rx_queue.sv
hw/rtl/uart_tx_rx_ring_buffers.sv
tb/tb.sv
